// ----- hw/rtl/dedup_bounded_fifo_defines.svh -----
// ----------------------------------------------------------------------------
// dedup bounded fifo assertion macros
// shared concurrent assertion forms for the dedup bounded fifo
// ----------------------------------------------------------------------------
`ifndef DEDUP_BOUNDED_FIFO_DEFINES_SVH
`define DEDUP_BOUNDED_FIFO_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dedup bounded fifo check failed");

// next-cycle implication, checked out of reset
`define DBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dedup bounded fifo check failed");

`endif

// ----- hw/rtl/dbf_pkg.sv -----
// ----------------------------------------------------------------------------
// dedup bounded fifo package
// payload types, status codes and defaults shared by the fifo modules
// ----------------------------------------------------------------------------
package dbf_pkg;

   localparam int ID_W        = 16;
   localparam int STATUS_W    = 3;
   localparam int OCC_W       = 5;
   localparam int CAP_W       = 5;
   localparam int DEPTH_DFLT  = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] item_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     item_out;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // per-cell control from the queue controller
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ----- hw/rtl/dbf_cell.sv -----
// ----------------------------------------------------------------------------
// dedup bounded fifo cell
// one queue entry: takes its neighbor's id on a pop, loads on a push, and
// compares its id against the probe
// ----------------------------------------------------------------------------
module dbf_cell (
   input  logic                     clock,
   input  dbf_pkg::cell_ctl_type    ctl,
   input  logic [dbf_pkg::ID_W-1:0] load_id,
   input  logic [dbf_pkg::ID_W-1:0] next_id,
   input  logic [dbf_pkg::ID_W-1:0] probe_id,
   output logic [dbf_pkg::ID_W-1:0] id_out,
   output logic                     match
);

   logic [dbf_pkg::ID_W-1:0] id_ff;
   logic [dbf_pkg::ID_W-1:0] id_in;

   always_comb begin
      priority if (ctl.shift) begin
         id_in = next_id;
      end else if (ctl.load) begin
         id_in = load_id;
      end else begin
         id_in = id_ff;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_out = id_ff;
   assign match  = (id_ff == probe_id);

endmodule

// ----- hw/rtl/dedup_bounded_fifo.sv -----
// ----------------------------------------------------------------------------
// dedup bounded fifo
// fifo of item ids with a settable capacity that refuses null, full and
// duplicate pushes
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one transaction: kind (push or pop) and item_id. every
//   transaction yields exactly one rsp_* transaction with status, the popped
//   id (zero on push or empty) and the occupancy after the operation.
//   csr_* writes the capacity register (5 bits); csr_ready is always high.
//   write it only while no transaction is in flight.
// pipeline and throughput:
//   a transaction is registered into the request register on acceptance and
//   executed once the response register can take it; its response is then
//   registered. one transaction per cycle is sustained while rsp_stall is
//   low; the duplicate check compares every held cell in the execute cycle.
// reset:
//   synchronous, clears occupancy and sets capacity to 16. cell contents are
//   not cleared; only cells below the occupancy count are ever used.
// stall:
//   while rsp_stall holds a pending response, execution waits and req_stall
//   rises once the request register is full; nothing is dropped.
// ----------------------------------------------------------------------------
module dedup_bounded_fifo #(
   parameter int DEPTH = dbf_pkg::DEPTH_DFLT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  dbf_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dbf_pkg::rsp_type          rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [dbf_pkg::CAP_W-1:0] csr_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + dbf_pkg::CAP_W;

   logic                      busy_ff, busy_in;
   dbf_pkg::req_type          req_ff, req_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   dbf_pkg::rsp_type          rsp_ff, rsp_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [dbf_pkg::CAP_W-1:0] cap_ff, cap_in;

   logic                      exec;
   logic                      accept;
   logic [XW-1:0]             cap_x;
   logic [XW-1:0]             cap_eff;
   logic                      full;
   logic                      dup;
   logic                      do_push;
   logic                      do_pop;

   dbf_pkg::cell_ctl_type     cell_ctl [DEPTH];
   logic [dbf_pkg::ID_W-1:0]  cell_id  [DEPTH];
   logic [DEPTH-1:0]          cell_match;
   logic [DEPTH-1:0]          held_mask;

   // execute when a request is held and the response register can take it
   assign exec      = busy_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = busy_ff && !exec;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign cap_x   = XW'(cap_ff);
   assign cap_eff = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
   assign full    = (XW'(count_ff) >= cap_eff);
   assign dup     = |(cell_match & held_mask);

   assign do_push = exec && (req_ff.kind == dbf_pkg::KIND_PUSH)
                    && (req_ff.item_id != '0) && !full && !dup;
   assign do_pop  = exec && (req_ff.kind == dbf_pkg::KIND_POP) && (count_ff != '0);

   // chain of cells, oldest entry in cell zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [dbf_pkg::ID_W-1:0] next_id;

      if (i == DEPTH - 1) begin : g_tail
         assign next_id = '0;
      end else begin : g_mid
         assign next_id = cell_id[i+1];
      end

      assign held_mask[i]      = (CW'(i) < count_ff);
      assign cell_ctl[i].shift = do_pop;
      assign cell_ctl[i].load  = do_push && (CW'(i) == count_ff);

      dbf_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .load_id  (req_ff.item_id),
         .next_id  (next_id),
         .probe_id (req_ff.item_id),
         .id_out   (cell_id[i]),
         .match    (cell_match[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_in.item_out  = '0;
      rsp_in.occupancy = dbf_pkg::OCC_W'(count_in);
      if (req_ff.kind == dbf_pkg::KIND_PUSH) begin
         priority if (req_ff.item_id == '0) begin
            rsp_in.status = dbf_pkg::ST_NULL;
         end else if (full) begin
            rsp_in.status = dbf_pkg::ST_FULL;
         end else if (dup) begin
            rsp_in.status = dbf_pkg::ST_DUP;
         end else begin
            rsp_in.status = dbf_pkg::ST_OK;
         end
      end else begin
         if (count_ff == '0) begin
            rsp_in.status = dbf_pkg::ST_EMPTY;
         end else begin
            rsp_in.status   = dbf_pkg::ST_OK;
            rsp_in.item_out = cell_id[0];
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      req_in  = req_ff;
      if (accept) begin
         busy_in = 1'b1;
         req_in  = req_payload;
      end else if (exec) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= dbf_pkg::CAP_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // assertions

`include "dedup_bounded_fifo_defines.svh"

   `DBF_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, (XW'(count_ff) <= XW'(DEPTH)))
   `DBF_ASSERT_NEXT(a_pop_drains, clock, reset, do_pop, (count_ff == $past(count_ff) - CW'(1)))
   `DBF_ASSERT_NOW(a_empty_occ, clock, reset,
      (rsp_valid_ff && (rsp_ff.status == dbf_pkg::ST_EMPTY)), (rsp_ff.occupancy == '0))
   `DBF_ASSERT_NOW(a_one_op, clock, reset, 1'b1, !(do_push && do_pop))

endmodule
